>>> sv/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int DATA_WIDTH = 32;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 1;
  localparam int CNT_WIDTH  = $clog2(SUM_WIDTH + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [DATA_WIDTH-1:0] a_num;
    logic signed [DATA_WIDTH-1:0] a_den;
    logic signed [DATA_WIDTH-1:0] b_num;
    logic signed [DATA_WIDTH-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_num;
    logic [DATA_WIDTH-2:0]        res_den;
    logic [1:0]                   status;
  } rau_out_t;
endpackage

>>> sv/rau_if.sv
// Valid/ready channel interface for the rational arithmetic unit.
// Depends on rau_pkg for payload widths.
`timescale 1ns / 1ps
interface rau_in_if;
  import rau_pkg::*;
  logic    valid;
  logic    ready;
  rau_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic     valid;
  logic     ready;
  rau_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/rau_alu.sv
// Shared arithmetic unit: one add/subtract/compare on SUM_WIDTH magnitudes.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_alu (
  input  logic [rau_pkg::SUM_WIDTH-1:0] x,
  input  logic [rau_pkg::SUM_WIDTH-1:0] y,
  input  logic                          sub,
  output logic [rau_pkg::SUM_WIDTH-1:0] res,
  output logic                          x_ge_y
);
  import rau_pkg::*;
  logic [SUM_WIDTH:0] diff;
  always_comb begin
    diff   = {1'b0, x} - {1'b0, y};
    x_ge_y = !diff[SUM_WIDTH];
    res    = sub ? diff[SUM_WIDTH-1:0] : (x + y);
  end
endmodule

>>> sv/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: sequencer, registers and shared ALU.
// Depends on rau_pkg, rau_if and rau_alu.
//
// Usage: items enter on in_ch (operation, a_num, a_den, b_num, b_den) and one
// result item leaves on out_ch (res_num, res_den, status) per input item.
// The block takes one item at a time; in_ch.ready is high only when idle and
// the output register is empty. Products are formed by shift-add after a load
// step (two or three products, in turn), the sum by an ALU pass that is
// repeated after a swap when the signs differ and the first magnitude is the
// smaller, the GCD by the Euclidean method with restoring remainders, and the
// two exact divisions by restoring division. All work goes through one shared
// add/subtract/compare unit. Reset returns the sequencer to idle and empties
// the output register. If the receiver stalls, the result is held in the
// output register and no new item is taken until it is delivered.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core (
  input  logic clk,
  input  logic rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_NEXT = 4'd2;
  localparam logic [3:0] S_ADD  = 4'd3;
  localparam logic [3:0] S_GCHK = 4'd4;
  localparam logic [3:0] S_GDIV = 4'd5;
  localparam logic [3:0] S_QDIV = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0] state;
  logic [1:0] step;
  logic [CNT_WIDTH-1:0] cnt;
  logic [1:0] op;
  logic [DATA_WIDTH-1:0] an, ad, bn, bd;
  logic sn_an, sn_ad, sn_bn, sn_bd;
  logic [SUM_WIDTH-1:0] acc, mcand;
  logic [DATA_WIDTH-1:0] mplier;
  logic [SUM_WIDTH-1:0] p0, p1;
  logic s0, s1, s2;
  logic [SUM_WIDTH-1:0] nmag, dmag, gx, gy;
  logic nneg;
  logic [SUM_WIDTH-1:0] rem, quo, dvd, dvs;
  logic qsel;
  logic out_valid;
  rau_out_t out_data;

  logic [SUM_WIDTH-1:0] alu_x, alu_y, alu_res;
  logic alu_sub, alu_ge;
  logic [SUM_WIDTH-1:0] rem_sh;

  rau_alu u_alu (.x(alu_x), .y(alu_y), .sub(alu_sub), .res(alu_res), .x_ge_y(alu_ge));

  function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
    mag_of = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  assign rem_sh = {rem[SUM_WIDTH-2:0], dvd[SUM_WIDTH-1]};

  always_comb begin
    alu_x = acc;
    alu_y = mcand;
    alu_sub = 1'b0;
    case (state)
      S_ADD: begin
        alu_x = p0;
        alu_y = p1;
        alu_sub = (s0 != s1);
      end
      S_GDIV, S_QDIV: begin
        alu_x = rem_sh;
        alu_y = dvs;
        alu_sub = 1'b1;
      end
      default: begin
        alu_x = acc;
        alu_y = mcand;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            op <= in_ch.data.operation;
            an <= mag_of(in_ch.data.a_num); sn_an <= in_ch.data.a_num[DATA_WIDTH-1];
            ad <= mag_of(in_ch.data.a_den); sn_ad <= in_ch.data.a_den[DATA_WIDTH-1];
            bn <= mag_of(in_ch.data.b_num); sn_bn <= in_ch.data.b_num[DATA_WIDTH-1];
            bd <= mag_of(in_ch.data.b_den); sn_bd <= in_ch.data.b_den[DATA_WIDTH-1];
            if (in_ch.data.a_den == '0 || in_ch.data.b_den == '0 ||
                (in_ch.data.operation == OP_DIV && in_ch.data.b_num == '0)) begin
              out_data <= '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
              out_valid <= 1'b1;
            end else begin
              step <= 2'd0;
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          // load multiplier pair for product number step
          acc <= '0;
          cnt <= '0;
          state <= S_MUL;
          case (step)
            2'd0: begin
              mcand <= SUM_WIDTH'(an);
              mplier <= (op == OP_MUL) ? bn : bd;
            end
            2'd1: begin
              mcand <= SUM_WIDTH'(ad);
              mplier <= (op == OP_DIV) ? bn : bd;
            end
            default: begin
              mcand <= SUM_WIDTH'(bn);
              mplier <= ad;
            end
          endcase
        end
        S_MUL: begin
          if (mplier[0]) acc <= alu_res;
          mcand <= {mcand[SUM_WIDTH-2:0], 1'b0};
          mplier <= mplier >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_WIDTH'(DATA_WIDTH - 1)) begin
            step <= step + 1'b1;
            case (step)
              2'd0: begin
                p0 <= mplier[0] ? alu_res : acc;
                s0 <= (op == OP_MUL) ? (sn_an ^ sn_bn) : (sn_an ^ sn_bd);
                state <= S_NEXT;
              end
              2'd1: begin
                dmag <= mplier[0] ? alu_res : acc;
                s2 <= (op == OP_DIV) ? (sn_ad ^ sn_bn) : (sn_ad ^ sn_bd);
                if (op == OP_MUL || op == OP_DIV) begin
                  nmag <= p0;
                  nneg <= s0;
                  state <= S_GCHK;
                  gx <= p0;
                  gy <= mplier[0] ? alu_res : acc;
                end else begin
                  state <= S_NEXT;
                end
              end
              default: begin
                p1 <= mplier[0] ? alu_res : acc;
                s1 <= (sn_bn ^ sn_ad) ^ (op == OP_SUB);
                state <= S_ADD;
              end
            endcase
          end
        end
        S_ADD: begin
          if (s0 == s1 || alu_ge) begin
            nmag <= alu_res;
            nneg <= s0;
            gx <= alu_res;
            gy <= dmag;
            state <= S_GCHK;
          end else begin
            // swap so the larger magnitude is subtracted from
            p0 <= p1;
            p1 <= p0;
            s0 <= s1;
            s1 <= s0;
          end
        end
        S_GCHK: begin
          if (gy == '0) begin
            // gx is the gcd; divide numerator first
            dvs <= gx;
            dvd <= nmag;
            rem <= '0;
            quo <= '0;
            cnt <= '0;
            qsel <= 1'b0;
            state <= S_QDIV;
          end else begin
            dvs <= gy;
            dvd <= gx;
            rem <= '0;
            cnt <= '0;
            state <= S_GDIV;
          end
        end
        S_GDIV: begin
          rem <= alu_ge ? alu_res : rem_sh;
          dvd <= {dvd[SUM_WIDTH-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_WIDTH'(SUM_WIDTH - 1)) begin
            gx <= gy;
            gy <= alu_ge ? alu_res : rem_sh;
            state <= S_GCHK;
          end
        end
        S_QDIV: begin
          rem <= alu_ge ? alu_res : rem_sh;
          quo <= {quo[SUM_WIDTH-2:0], alu_ge};
          dvd <= {dvd[SUM_WIDTH-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_WIDTH'(SUM_WIDTH - 1)) begin
            cnt <= '0;
            rem <= '0;
            quo <= '0;
            if (!qsel) begin
              nmag <= {quo[SUM_WIDTH-2:0], alu_ge};
              dvd <= dmag;
              qsel <= 1'b1;
            end else begin
              dmag <= {quo[SUM_WIDTH-2:0], alu_ge};
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            if (dmag[SUM_WIDTH-1:DATA_WIDTH-1] != '0 ||
                ((nneg && nmag != '0 && s2 == 1'b0) || (!nneg && nmag != '0 && s2)
                  ? (nmag > (SUM_WIDTH'(1) << (DATA_WIDTH - 1)))
                  : (nmag[SUM_WIDTH-1:DATA_WIDTH-1] != '0))) begin
              out_data <= '{res_num: '0, res_den: '0, status: ST_OVERFLOW};
            end else if ((nneg != s2) && nmag != '0) begin
              out_data <= '{res_num: DATA_WIDTH'(~nmag + 1'b1),
                            res_den: dmag[DATA_WIDTH-2:0], status: ST_OK};
            end else begin
              out_data <= '{res_num: nmag[DATA_WIDTH-1:0],
                            res_den: dmag[DATA_WIDTH-2:0], status: ST_OK};
            end
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
